// File: rtl/ntrd_pkg.sv
// Package for the nibble table run decoder.
// Holds the payload structs, code constants, state enums and the
// controller-to-datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package ntrd_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 64;
    localparam int TAB_HIGH_W  = 48;

    localparam logic [CFG_INDEX_W-1:0] REG_TABLE_LOW  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TABLE_HIGH = 8'd1;

    localparam logic [3:0] CODE_RAW    = 4'hf;
    localparam logic [3:0] CODE_REPEAT = 4'he;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       has_char;
        logic       last_out;
    } out_item_t;

    typedef enum logic [1:0] {
        PH_CODE,
        PH_RAW_LO,
        PH_RAW_HI,
        PH_REPEAT
    } phase_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_EMIT,
        S_MARK
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic decode;
        logic emit;
        logic mark;
        logic next_nib;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic dec_emits;
        logic nib_hi;
        logic copies_zero;
        logic out_free;
        logic last;
        logic emitted;
    } dp_status_t;

endpackage

// File: rtl/nibble_table_run_decoder_unit.sv
// Top level of the nibble table run decoder.
// Depends on ntrd_pkg, ntrd_controller and ntrd_datapath.
//
// The input channel takes one compressed record byte per transaction, with
// a flag that marks the final byte of the record. The output channel gives
// one decoded character per transaction, or a single end marker with
// has_char low when the final byte produces no character. The
// configuration channel writes the two character table registers; it is
// always ready and must be used only while the decoder is idle.
// A byte is accepted only while the sequencer is idle. The sequencer then
// decodes the low nibble and emits each result it yields, then decodes the
// high nibble and emits each of its results or the end marker, and only
// then takes a new byte. A byte yields 0 to 18 results, or the end marker.
// A character passes through the byte, character and output registers;
// the end marker is written straight into the output register.
// Results leave through one output register; while the receiver stalls,
// the sequencer waits on that register and input stays stalled. Reset
// clears the tables, the decode state and the output valid.
`timescale 1ns / 1ps

module nibble_table_run_decoder_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ntrd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ntrd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  ntrd_pkg::in_item_t               in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output ntrd_pkg::out_item_t              out_data
);
    import ntrd_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    ntrd_controller u_controller (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    ntrd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

// File: rtl/ntrd_datapath.sv
// Datapath of the nibble table run decoder: table registers, decode state,
// repeat counter and the output register. Depends on ntrd_pkg.
`timescale 1ns / 1ps

module ntrd_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ntrd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ntrd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  ntrd_pkg::in_item_t                 in_data,
    input  ntrd_pkg::dp_cmd_t                  cmd,
    output ntrd_pkg::dp_status_t               status,
    input  logic                               out_stall,
    output logic                               out_valid,
    output ntrd_pkg::out_item_t                out_data
);
    import ntrd_pkg::*;

    logic [CFG_DATA_W-1:0] table_low_reg, table_low_next;
    logic [TAB_HIGH_W-1:0] table_high_reg, table_high_next;
    phase_t                phase_reg, phase_next;
    logic [3:0]            raw_reg, raw_next;
    logic [4:0]            rep_reg, rep_next;
    logic [4:0]            copies_reg, copies_next;
    logic                  nib_sel_reg, nib_sel_next;
    logic                  emitted_reg, emitted_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            byte_reg, byte_next;
    logic                  last_reg, last_next;
    logic [7:0]            char_reg, char_next;
    out_item_t             out_data_reg, out_data_next;

    logic [7:0] tab [16];
    logic [3:0] nib;
    logic [3:0] hi_nib;
    logic [7:0] dec_char;
    logic       dec_emits;
    phase_t     dec_phase;
    logic [3:0] dec_raw;
    logic [4:0] dec_rep;
    logic       hi_emits;
    logic       out_free;

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            tab[k] = table_low_reg[8*k +: 8];
        end
        for (int k = 0; k < 6; k++)
        begin
            tab[8+k] = table_high_reg[8*k +: 8];
        end
        tab[14] = 8'd0;
        tab[15] = 8'd0;
    end

    assign hi_nib = byte_reg[7:4];
    assign nib    = nib_sel_reg ? byte_reg[7:4] : byte_reg[3:0];

    always_comb
    begin
        dec_char  = 8'd0;
        dec_emits = 1'b0;
        dec_phase = phase_reg;
        dec_raw   = raw_reg;
        dec_rep   = rep_reg;
        case (phase_reg)
            PH_CODE:
            begin
                if (nib == CODE_RAW)
                begin
                    dec_phase = PH_RAW_LO;
                end
                else if (nib == CODE_REPEAT)
                begin
                    dec_phase = PH_REPEAT;
                end
                else
                begin
                    dec_char  = tab[nib];
                    dec_emits = 1'b1;
                end
            end
            PH_RAW_LO:
            begin
                dec_raw   = nib;
                dec_phase = PH_RAW_HI;
            end
            PH_RAW_HI:
            begin
                dec_char  = {nib, raw_reg};
                dec_emits = 1'b1;
                dec_phase = PH_CODE;
            end
            PH_REPEAT:
            begin
                dec_rep   = {1'b0, nib} + 5'd1;
                dec_phase = PH_CODE;
            end
            default:
            begin
                dec_phase = PH_CODE;
            end
        endcase
    end

    assign hi_emits = ((phase_reg == PH_CODE) && (hi_nib < CODE_REPEAT))
                      || (phase_reg == PH_RAW_HI);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        table_low_next  = table_low_reg;
        table_high_next = table_high_reg;
        phase_next      = phase_reg;
        raw_next        = raw_reg;
        rep_next        = rep_reg;
        copies_next     = copies_reg;
        nib_sel_next    = nib_sel_reg;
        emitted_next    = emitted_reg;
        byte_next       = byte_reg;
        last_next       = last_reg;
        char_next       = char_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && out_stall;

        if (cfg_we)
        begin
            if (cfg_index == REG_TABLE_LOW)
            begin
                table_low_next = cfg_data;
            end
            else if (cfg_index == REG_TABLE_HIGH)
            begin
                table_high_next = cfg_data[TAB_HIGH_W-1:0];
            end
        end

        if (cmd.load)
        begin
            byte_next    = in_data.data_byte;
            last_next    = in_data.last_byte;
            nib_sel_next = 1'b0;
            emitted_next = 1'b0;
        end

        if (cmd.decode)
        begin
            phase_next = dec_phase;
            raw_next   = dec_raw;
            rep_next   = dec_rep;
            if (dec_emits)
            begin
                char_next   = dec_char;
                copies_next = rep_reg;
                rep_next    = 5'd0;
            end
        end

        if (cmd.emit)
        begin
            out_valid_next         = 1'b1;
            out_data_next.char_out = char_reg;
            out_data_next.has_char = 1'b1;
            out_data_next.last_out = last_reg && (copies_reg == 5'd0)
                                     && (nib_sel_reg || !hi_emits);
            emitted_next           = 1'b1;
            if (copies_reg != 5'd0)
            begin
                copies_next = copies_reg - 5'd1;
            end
        end

        if (cmd.mark)
        begin
            out_valid_next         = 1'b1;
            out_data_next.char_out = 8'd0;
            out_data_next.has_char = 1'b0;
            out_data_next.last_out = 1'b1;
        end

        if (cmd.next_nib)
        begin
            nib_sel_next = 1'b1;
        end

        if (cmd.finish && last_reg)
        begin
            phase_next = PH_CODE;
            raw_next   = 4'd0;
            rep_next   = 5'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_low_reg  <= '0;
            table_high_reg <= '0;
            phase_reg      <= PH_CODE;
            raw_reg        <= 4'd0;
            rep_reg        <= 5'd0;
            copies_reg     <= 5'd0;
            nib_sel_reg    <= 1'b0;
            emitted_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            table_low_reg  <= table_low_next;
            table_high_reg <= table_high_next;
            phase_reg      <= phase_next;
            raw_reg        <= raw_next;
            rep_reg        <= rep_next;
            copies_reg     <= copies_next;
            nib_sel_reg    <= nib_sel_next;
            emitted_reg    <= emitted_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        last_reg     <= last_next;
        char_reg     <= char_next;
        out_data_reg <= out_data_next;
    end

    assign status.dec_emits   = dec_emits;
    assign status.nib_hi      = nib_sel_reg;
    assign status.copies_zero = (copies_reg == 5'd0);
    assign status.out_free    = out_free;
    assign status.last        = last_reg;
    assign status.emitted     = emitted_reg;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: rtl/ntrd_controller.sv
// Controller of the nibble table run decoder: sequences byte load, nibble
// decode, character copies and the end marker. Depends on ntrd_pkg.
`timescale 1ns / 1ps

module ntrd_controller (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  ntrd_pkg::dp_status_t  status,
    output ntrd_pkg::dp_cmd_t     cmd
);
    import ntrd_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (status.dec_emits)
                begin
                    state_next = S_EMIT;
                end
                else if (!status.nib_hi)
                begin
                    state_next = S_DECODE;
                end
                else if (status.last && !status.emitted)
                begin
                    state_next = S_MARK;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (status.out_free && status.copies_zero)
                begin
                    state_next = status.nib_hi ? S_IDLE : S_DECODE;
                end
            end
            S_MARK:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            S_DECODE:
            begin
                cmd.decode   = 1'b1;
                cmd.next_nib = !status.dec_emits && !status.nib_hi;
                cmd.finish   = !status.dec_emits && status.nib_hi;
            end
            S_EMIT:
            begin
                cmd.emit     = status.out_free;
                cmd.next_nib = status.out_free && status.copies_zero && !status.nib_hi;
                cmd.finish   = status.out_free && status.copies_zero && status.nib_hi;
            end
            S_MARK:
            begin
                cmd.mark = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
